// File: hw/rtl/mbrc_pkg.sv
package mbrc_pkg;

	localparam logic [1:0] OP_ARM  = 2'd0;
	localparam logic [1:0] OP_BYTE = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_TIMEOUT = 3'd1;
	localparam logic [2:0] ST_ADDR    = 3'd2;
	localparam logic [2:0] ST_FUNC    = 3'd3;
	localparam logic [2:0] ST_CRC     = 3'd4;

	localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_FUNCTION_CODE  = 2'd1;
	localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd2;

	localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd1;
	localparam logic [7:0]  RST_FUNCTION_CODE  = 8'd4;
	localparam logic [9:0]  RST_TIMEOUT_TICKS  = 10'd200;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] ERR_VALUE = 16'hFFFF;

	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] function_code;
		logic [9:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic        fire;
		logic [2:0]  status;
		logic [15:0] value;
	} res_t;

	function automatic logic [15:0] crc_feed(logic [15:0] crc_in, logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/mbrc_frame.sv
module mbrc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic              enable,
	input  logic [1:0]        operation,
	input  logic [7:0]        rx_byte,
	input  mbrc_pkg::cfg_t    cfg,
	output mbrc_pkg::res_t    res
);

	logic        armed_q,   armed_d;
	logic [2:0]  count_q,   count_d;
	logic [15:0] crc_q,     crc_d;
	logic [2:0]  err_q,     err_d;
	logic [9:0]  elapsed_q, elapsed_d;
	logic [7:0]  vhi_q,     vhi_d;
	logic [7:0]  vlo_q,     vlo_d;
	logic [7:0]  crclo_q,   crclo_d;
	logic [9:0]  tick_next;
	logic [9:0]  limit;

	assign tick_next = elapsed_q + 10'd1;
	assign limit     = (cfg.timeout_ticks == 10'd0) ? 10'd1 : cfg.timeout_ticks;

	always_comb begin
		res       = '0;
		armed_d   = armed_q;
		count_d   = count_q;
		crc_d     = crc_q;
		err_d     = err_q;
		elapsed_d = elapsed_q;
		vhi_d     = vhi_q;
		vlo_d     = vlo_q;
		crclo_d   = crclo_q;
		if (valid) begin
			case (operation)
				mbrc_pkg::OP_ARM: begin
					armed_d   = 1'b1;
					count_d   = 3'd0;
					crc_d     = mbrc_pkg::CRC_INIT;
					err_d     = mbrc_pkg::ST_OK;
					elapsed_d = 10'd0;
				end
				mbrc_pkg::OP_TICK: begin
					if (armed_q) begin
						elapsed_d = tick_next;
						if (tick_next >= limit) begin
							res.fire   = 1'b1;
							res.status = mbrc_pkg::ST_TIMEOUT;
							res.value  = mbrc_pkg::ERR_VALUE;
						end
					end
				end
				mbrc_pkg::OP_BYTE: begin
					if (armed_q) begin
						count_d = count_q + 3'd1;
						unique case (count_q)
							3'd0: begin
								if (rx_byte != cfg.device_address && err_q == mbrc_pkg::ST_OK) begin
									err_d = mbrc_pkg::ST_ADDR;
								end
								crc_d = mbrc_pkg::crc_feed(crc_q, rx_byte);
							end
							3'd1: begin
								if (rx_byte != cfg.function_code && err_q == mbrc_pkg::ST_OK) begin
									err_d = mbrc_pkg::ST_FUNC;
								end
								crc_d = mbrc_pkg::crc_feed(crc_q, rx_byte);
							end
							3'd2: begin
								crc_d = mbrc_pkg::crc_feed(crc_q, rx_byte);
							end
							3'd3: begin
								vhi_d = rx_byte;
								crc_d = mbrc_pkg::crc_feed(crc_q, rx_byte);
							end
							3'd4: begin
								vlo_d = rx_byte;
								crc_d = mbrc_pkg::crc_feed(crc_q, rx_byte);
							end
							3'd5: begin
								crclo_d = rx_byte;
							end
							default: begin
								res.fire = 1'b1;
								if (err_q != mbrc_pkg::ST_OK) begin
									res.status = err_q;
									res.value  = mbrc_pkg::ERR_VALUE;
								end else if ({rx_byte, crclo_q} != crc_q) begin
									res.status = mbrc_pkg::ST_CRC;
									res.value  = mbrc_pkg::ERR_VALUE;
								end else begin
									res.status = mbrc_pkg::ST_OK;
									res.value  = {vhi_q, vlo_q};
								end
							end
						endcase
					end
				end
				default: begin
				end
			endcase
			if (res.fire) begin
				armed_d   = 1'b0;
				count_d   = 3'd0;
				crc_d     = mbrc_pkg::CRC_INIT;
				err_d     = mbrc_pkg::ST_OK;
				elapsed_d = 10'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			count_q   <= 3'd0;
			crc_q     <= mbrc_pkg::CRC_INIT;
			err_q     <= mbrc_pkg::ST_OK;
			elapsed_q <= 10'd0;
		end else if (enable) begin
			armed_q   <= armed_d;
			count_q   <= count_d;
			crc_q     <= crc_d;
			err_q     <= err_d;
			elapsed_q <= elapsed_d;
		end
	end

	// frame payload bytes, written before use
	always_ff @(posedge clk) begin
		if (enable) begin
			vhi_q   <= vhi_d;
			vlo_q   <= vlo_d;
			crclo_q <= crclo_d;
		end
	end

endmodule

// File: hw/rtl/modbus_rtu_response_check_core.sv
// the word that completes a result is registered in the input stage, and the result then in the output register
// throughput: one input word per cycle while the input does not stall; the crc update is one unrolled byte step
// input stalls only while a result is held in the output register and stalled
// reset (arst_n, async, active low): idle, no frame armed, config registers at defaults
// device_address 1, function_code 4, timeout_ticks 200
module modbus_rtu_response_check_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [15:0] register_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	mbrc_pkg::cfg_t cfg_q;
	mbrc_pkg::res_t res;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;
	logic        step;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] value_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= mbrc_pkg::RST_DEVICE_ADDRESS;
			cfg_q.function_code  <= mbrc_pkg::RST_FUNCTION_CODE;
			cfg_q.timeout_ticks  <= mbrc_pkg::RST_TIMEOUT_TICKS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mbrc_pkg::CFG_DEVICE_ADDRESS: cfg_q.device_address <= cfg_data[7:0];
				mbrc_pkg::CFG_FUNCTION_CODE:  cfg_q.function_code  <= cfg_data[7:0];
				mbrc_pkg::CFG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// hold the input stage only when its result has nowhere to go
	assign step       = valid_s1 & ~(res.fire & out_valid_q & result_stall);
	assign item_stall = valid_s1 & ~step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	mbrc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.enable    (step),
		.operation (op_s1),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.fire) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.fire) begin
			status_q <= res.status;
			value_q  <= res.value;
		end
	end

	assign result_valid   = out_valid_q;
	assign status         = status_q;
	assign register_value = value_q;

endmodule
